@@ rtl/gnic_pkg.sv @@
// gnic_pkg: shared types and constants for the gigabit nic register block
// register offsets, opcodes, config indexes and the request/response structs
// no dependencies
`default_nettype none

package gnic_pkg;

  localparam int OfsW       = 17;
  localparam int DataW      = 32;
  localparam int MacW       = 48;
  localparam int EntriesW   = 28;
  localparam int SizeW      = 4;
  localparam int OpW        = 2;
  localparam int CfgIdxW    = 1;

  localparam int WindowBytes = 131072;
  localparam int EepromWords = 64;
  localparam int RspDepth    = 4;

  localparam logic [SizeW-1:0] LegalSize = SizeW'(4);

  localparam logic [OfsW-1:0] OfsCtrl   = 17'h00000;
  localparam logic [OfsW-1:0] OfsStatus = 17'h00008;
  localparam logic [OfsW-1:0] OfsEecd   = 17'h00010;
  localparam logic [OfsW-1:0] OfsEerd   = 17'h00014;
  localparam logic [OfsW-1:0] OfsIcr    = 17'h000C0;
  localparam logic [OfsW-1:0] OfsIms    = 17'h000D0;
  localparam logic [OfsW-1:0] OfsImc    = 17'h000D8;
  localparam logic [OfsW-1:0] OfsRctl   = 17'h00100;
  localparam logic [OfsW-1:0] OfsTctl   = 17'h00400;
  localparam logic [OfsW-1:0] OfsRdbal  = 17'h02800;
  localparam logic [OfsW-1:0] OfsRdbah  = 17'h02804;
  localparam logic [OfsW-1:0] OfsRdlen  = 17'h02808;
  localparam logic [OfsW-1:0] OfsRdh    = 17'h02810;
  localparam logic [OfsW-1:0] OfsRdt    = 17'h02818;
  localparam logic [OfsW-1:0] OfsTdbal  = 17'h03800;
  localparam logic [OfsW-1:0] OfsTdbah  = 17'h03804;
  localparam logic [OfsW-1:0] OfsTdlen  = 17'h03808;
  localparam logic [OfsW-1:0] OfsTdh    = 17'h03810;
  localparam logic [OfsW-1:0] OfsTdt    = 17'h03818;
  localparam logic [OfsW-1:0] OfsRal0   = 17'h05400;
  localparam logic [OfsW-1:0] OfsRah0   = 17'h05404;

  localparam int CtrlRstBit = 26;
  localparam int RingEnBit  = 1;

  localparam logic [DataW-1:0] LinkStatus = 32'h0000_0083;
  localparam logic [DataW-1:0] EePresent  = 32'h0000_0100;
  localparam logic [DataW-1:0] EerdDone   = 32'h0000_0010;
  localparam logic [DataW-1:0] AddrValid  = 32'h8000_0000;
  localparam logic [DataW-1:0] BaseMask   = 32'hFFFF_FFF0;
  localparam logic [DataW-1:0] LenMask    = 32'hFFFF_FF80;

  typedef enum logic [OpW-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_RAISE = 2'd2
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAC_ADDRESS = 1'b0,
    CFG_BUS_MASTER  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [OfsW-1:0]  reg_offset;
    logic [SizeW-1:0] access_size;
    logic [DataW-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0]    read_data;
    logic                access_error;
    logic                irq_pending;
    logic                tx_ready;
    logic                rx_ready;
    logic [EntriesW-1:0] tx_ring_entries;
    logic [EntriesW-1:0] rx_ring_entries;
    logic                station_ok;
  } rsp_t;

endpackage

`default_nettype wire

@@ rtl/gnic_if.sv @@
// gnic_req_if / gnic_rsp_if: valid/ready channels for bus beats and results
// depends on gnic_pkg for field widths
`default_nettype none

interface gnic_req_if
  import gnic_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [OpW-1:0]   opcode;
  logic [OfsW-1:0]  reg_offset;
  logic [SizeW-1:0] access_size;
  logic [DataW-1:0] write_data;

  modport source (output valid, output opcode, output reg_offset,
                  output access_size, output write_data, input ready);
  modport sink   (input valid, input opcode, input reg_offset,
                  input access_size, input write_data, output ready);
endinterface

interface gnic_rsp_if
  import gnic_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [DataW-1:0]    read_data;
  logic                access_error;
  logic                irq_pending;
  logic                tx_ready;
  logic                rx_ready;
  logic [EntriesW-1:0] tx_ring_entries;
  logic [EntriesW-1:0] rx_ring_entries;
  logic                station_ok;

  modport source (output valid, output read_data, output access_error,
                  output irq_pending, output tx_ready, output rx_ready,
                  output tx_ring_entries, output rx_ring_entries,
                  output station_ok, input ready);
  modport sink   (input valid, input read_data, input access_error,
                  input irq_pending, input tx_ready, input rx_ready,
                  input tx_ring_entries, input rx_ring_entries,
                  input station_ok, output ready);
endinterface

`default_nettype wire

@@ rtl/gnic_regs.sv @@
// gnic_regs: register state, access decode and status for one staged beat
// depends on gnic_pkg
`default_nettype none

module gnic_regs
  import gnic_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [MacW-1:0]    cfg_data_i,
  input  wire logic               commit_i,
  input  wire req_t               req_i,
  output rsp_t                    rsp_o
);

  typedef struct packed {
    logic [DataW-1:0] ctrl;
    logic [DataW-1:0] rctl;
    logic [DataW-1:0] tctl;
    logic [DataW-1:0] ims;
    logic [DataW-1:0] icr;
    logic [DataW-1:0] eerd;
    logic [DataW-1:0] rdbal;
    logic [DataW-1:0] rdbah;
    logic [DataW-1:0] rdlen;
    logic [15:0]      rdh;
    logic [15:0]      rdt;
    logic [DataW-1:0] tdbal;
    logic [DataW-1:0] tdbah;
    logic [DataW-1:0] tdlen;
    logic [15:0]      tdh;
    logic [15:0]      tdt;
  } state_t;

  state_t          st_q, st_d;
  logic [MacW-1:0] mac_q;
  logic            bme_q;

  logic             access_ok;
  logic             rd_ok, wr_ok;
  logic [DataW-1:0] rdata;
  logic [15:0]      ee_addr;
  logic [15:0]      ee_word;
  logic [DataW-1:0] wdata;
  logic [OfsW-1:0]  ofs;

  assign ofs       = req_i.reg_offset;
  assign wdata     = req_i.write_data;
  assign access_ok = (req_i.access_size == LegalSize) &&
                     ({1'b0, ofs} < (OfsW+1)'(WindowBytes)) &&
                     (ofs[1:0] == 2'b00);
  assign rd_ok = commit_i && (req_i.opcode == OP_READ) && access_ok;
  assign wr_ok = commit_i && (req_i.opcode == OP_WRITE) && access_ok;

  // eeprom words 0..2 carry the station address
  assign ee_addr = st_q.eerd[23:8];
  always_comb begin
    ee_word = '0;
    if ((ee_addr < 16'(EepromWords)) && (ee_addr <= 16'd2)) begin
      case (ee_addr[1:0])
        2'd0:    ee_word = mac_q[15:0];
        2'd1:    ee_word = mac_q[31:16];
        2'd2:    ee_word = mac_q[47:32];
        default: ee_word = '0;
      endcase
    end
  end

  always_comb begin
    case (ofs)
      OfsCtrl:   rdata = st_q.ctrl & ~(DataW'(1) << CtrlRstBit);
      OfsStatus: rdata = LinkStatus;
      OfsEecd:   rdata = EePresent;
      OfsEerd:   rdata = {ee_word, st_q.eerd[15:0]} | EerdDone;
      OfsIcr:    rdata = st_q.icr;
      OfsIms:    rdata = st_q.ims;
      OfsRctl:   rdata = st_q.rctl;
      OfsTctl:   rdata = st_q.tctl;
      OfsRdbal:  rdata = st_q.rdbal;
      OfsRdbah:  rdata = st_q.rdbah;
      OfsRdlen:  rdata = st_q.rdlen;
      OfsRdh:    rdata = DataW'(st_q.rdh);
      OfsRdt:    rdata = DataW'(st_q.rdt);
      OfsTdbal:  rdata = st_q.tdbal;
      OfsTdbah:  rdata = st_q.tdbah;
      OfsTdlen:  rdata = st_q.tdlen;
      OfsTdh:    rdata = DataW'(st_q.tdh);
      OfsTdt:    rdata = DataW'(st_q.tdt);
      OfsRal0:   rdata = mac_q[31:0];
      OfsRah0:   rdata = DataW'(mac_q[47:32]) | AddrValid;
      default:   rdata = '0;
    endcase
  end

  always_comb begin
    st_d = st_q;
    if (rd_ok && (ofs == OfsIcr)) begin
      st_d.icr = '0;
    end
    if (commit_i && (req_i.opcode == OP_RAISE)) begin
      st_d.icr = st_q.icr | wdata;
    end
    if (wr_ok) begin
      case (ofs)
        OfsCtrl: begin
          if (wdata[CtrlRstBit]) begin
            st_d = '0;
          end else begin
            st_d.ctrl = wdata;
          end
        end
        OfsRctl:  st_d.rctl  = wdata;
        OfsTctl:  st_d.tctl  = wdata;
        OfsIms:   st_d.ims   = st_q.ims | wdata;
        OfsImc:   st_d.ims   = st_q.ims & ~wdata;
        OfsIcr:   st_d.icr   = st_q.icr & ~wdata;
        OfsEerd:  st_d.eerd  = wdata;
        OfsRdbal: st_d.rdbal = wdata & BaseMask;
        OfsRdbah: st_d.rdbah = wdata;
        OfsRdlen: st_d.rdlen = wdata & LenMask;
        OfsRdh:   st_d.rdh   = wdata[15:0];
        OfsRdt:   st_d.rdt   = wdata[15:0];
        OfsTdbal: st_d.tdbal = wdata & BaseMask;
        OfsTdbah: st_d.tdbah = wdata;
        OfsTdlen: st_d.tdlen = wdata & LenMask;
        OfsTdh:   st_d.tdh   = wdata[15:0];
        OfsTdt:   st_d.tdt   = wdata[15:0];
        default:  ;
      endcase
    end
  end

  // status is taken from the state after this beat
  always_comb begin
    rsp_o = '0;
    rsp_o.read_data       = rd_ok ? rdata : '0;
    rsp_o.access_error    = commit_i && !access_ok &&
                            ((req_i.opcode == OP_READ) || (req_i.opcode == OP_WRITE));
    rsp_o.irq_pending     = |(st_d.icr & st_d.ims);
    rsp_o.tx_ring_entries = st_d.tdlen[DataW-1:4];
    rsp_o.rx_ring_entries = st_d.rdlen[DataW-1:4];
    rsp_o.tx_ready        = st_d.tctl[RingEnBit] && (|st_d.tdlen[DataW-1:4]) &&
                            ((|st_d.tdbal) || (|st_d.tdbah)) && bme_q;
    rsp_o.rx_ready        = st_d.rctl[RingEnBit] && (|st_d.rdlen[DataW-1:4]) &&
                            ((|st_d.rdbal) || (|st_d.rdbah)) && bme_q;
    rsp_o.station_ok      = (|mac_q) && !mac_q[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= '0;
      mac_q <= '0;
      bme_q <= 1'b1;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MAC_ADDRESS: mac_q <= cfg_data_i;
          CFG_BUS_MASTER:  bme_q <= cfg_data_i[0];
          default:         ;
        endcase
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_ok && (ofs == OfsIcr)) |=> (st_q.icr == '0))
    else $error("icr not cleared by read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ok && (ofs == OfsCtrl) && wdata[CtrlRstBit]) |=>
      ((st_q.ims == '0) && (st_q.rdlen == '0) && (st_q.tdlen == '0) && (st_q.icr == '0)))
    else $error("device reset left state behind");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.rdlen[6:0] == 7'd0) && (st_q.tdlen[6:0] == 7'd0) &&
    (st_q.rdbal[3:0] == 4'd0) && (st_q.tdbal[3:0] == 4'd0))
    else $error("ring register alignment broken");

endmodule

`default_nettype wire

@@ rtl/gnic_rsp_fifo.sv @@
// gnic_rsp_fifo: small result queue between the register stage and the output
// depends on gnic_pkg for the result struct
`default_nettype none

module gnic_rsp_fifo
  import gnic_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire rsp_t                       data_i,
  input  wire logic                       pop_i,
  output rsp_t                            data_o,
  output logic                            valid_o,
  output logic [$clog2(DEPTH+1)-1:0]      count_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH+1);

  rsp_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_pop;

  assign valid_o = (cnt_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != CntW'(DEPTH)))
    else $error("result queue overflow");

endmodule

`default_nettype wire

@@ rtl/gigabit_nic_register_block.sv @@
// gigabit_nic_register_block: 8254x style register window, one beat per cycle
// channels: req_i carries read, write or raise beats; rsp_o returns one result
// per beat. cfg_we_i/cfg_idx_i/cfg_data_i write the station address (index 0)
// and bus master enable (index 1); the user must write them only while the
// block is idle; the block itself does not enforce this. a beat is captured
// in an input register, then decoded and committed to the register state in the
// next cycle; its result enters a four-entry queue and is offered on rsp_o
// once the results ahead of it have been taken. throughput is one beat per
// cycle while rsp_o takes results, set by the register read-modify-write.
// when rsp_o stalls, results collect in the queue; req_i.ready drops once the
// queue plus the beat in the input register would leave fewer than two free
// entries, and nothing is lost.
// reset clears all registers and the queue; station address resets to zero
// and bus master enable to one.
// depends on gnic_pkg, gnic_if, gnic_regs, gnic_rsp_fifo
`default_nettype none

module gigabit_nic_register_block
  import gnic_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  gnic_req_if.sink                req_i,
  gnic_rsp_if.source              rsp_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [MacW-1:0]    cfg_data_i
);

  localparam int CntW = $clog2(RspDepth+1);

  logic            stage_valid_q;
  req_t            stage_req_q;
  logic            in_fire;
  rsp_t            rsp_d;
  rsp_t            rsp_q;
  logic [CntW-1:0] fifo_cnt;
  logic            fifo_valid;

  assign req_i.ready = ((CntW+1)'(fifo_cnt) + (CntW+1)'(stage_valid_q))
                       < (CntW+1)'(RspDepth-1);
  assign in_fire     = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stage_req_q.opcode      <= req_i.opcode;
      stage_req_q.reg_offset  <= req_i.reg_offset;
      stage_req_q.access_size <= req_i.access_size;
      stage_req_q.write_data  <= req_i.write_data;
    end
  end

  gnic_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .commit_i   (stage_valid_q),
    .req_i      (stage_req_q),
    .rsp_o      (rsp_d)
  );

  gnic_rsp_fifo #(
    .DEPTH (RspDepth)
  ) u_rsp_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (stage_valid_q),
    .data_i  (rsp_d),
    .pop_i   (rsp_o.ready),
    .data_o  (rsp_q),
    .valid_o (fifo_valid),
    .count_o (fifo_cnt)
  );

  assign rsp_o.valid           = fifo_valid;
  assign rsp_o.read_data       = rsp_q.read_data;
  assign rsp_o.access_error    = rsp_q.access_error;
  assign rsp_o.irq_pending     = rsp_q.irq_pending;
  assign rsp_o.tx_ready        = rsp_q.tx_ready;
  assign rsp_o.rx_ready        = rsp_q.rx_ready;
  assign rsp_o.tx_ring_entries = rsp_q.tx_ring_entries;
  assign rsp_o.rx_ring_entries = rsp_q.rx_ring_entries;
  assign rsp_o.station_ok      = rsp_q.station_ok;

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// tb: self-checking bench for gigabit_nic_register_block
// drives directed and random register beats, predicts each result from a shadow
// copy of the register state and checks it; depends on gnic_pkg, gnic_if and the rtl
`timescale 1ns / 1ps

module tb
  import gnic_pkg::*;
();

  localparam logic [OpW-1:0] OpUnused   = 2'd3;
  localparam int             StallLimit = 2000;
  localparam int             Phases     = 5;
  localparam int             PhaseBeats = 110;

  typedef struct packed {
    logic [31:0] ctrl, rctl, tctl, ims, icr, eerd;
    logic [31:0] rdbal, rdbah, rdlen, tdbal, tdbah, tdlen;
    logic [15:0] rdh, rdt, tdh, tdt;
  } nic_regs_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [MacW-1:0]    cfg_data_i;

  gnic_req_if req_if ();
  gnic_rsp_if rsp_if ();

  gigabit_nic_register_block u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  nic_regs_t   nic_regs;
  logic [47:0] station_mac;
  logic        bus_master_on;

  req_t pending_beats[$];
  rsp_t expected_rsp_q[$];
  req_t beat_now;

  logic [OfsW-1:0] known_ofs [0:20] = '{
    OfsCtrl, OfsStatus, OfsEecd, OfsEerd, OfsIcr, OfsIms, OfsImc, OfsRctl, OfsTctl,
    OfsRdbal, OfsRdbah, OfsRdlen, OfsRdh, OfsRdt, OfsTdbal, OfsTdbah, OfsTdlen,
    OfsTdh, OfsTdt, OfsRal0, OfsRah0
  };

  int beats_queued, beats_sent, results_seen, mismatches;
  int n_reads, n_writes, n_raises, n_flagged, n_settings;
  int gap_left, stall_left, idle_cycles;
  bit send_burst, take_burst;

  function automatic rsp_t predict_beat(req_t b);
    rsp_t        r;
    logic [15:0] word_addr;
    logic [27:0] tx_n, rx_n;
    r = '0;
    case (b.opcode)
      OP_READ, OP_WRITE: begin
        if (b.access_size != LegalSize || b.reg_offset[1:0] != 2'b00 ||
            int'(b.reg_offset) >= WindowBytes) begin
          r.access_error = 1'b1;
        end else if (b.opcode == OP_READ) begin
          case (b.reg_offset)
            OfsCtrl:   r.read_data = nic_regs.ctrl & ~(32'd1 << CtrlRstBit);
            OfsStatus: r.read_data = LinkStatus;
            OfsEecd:   r.read_data = EePresent;
            OfsEerd: begin
              word_addr = nic_regs.eerd[23:8];
              r.read_data = {16'h0, nic_regs.eerd[15:0]} | EerdDone;
              if (word_addr < 16'd3 && int'(word_addr) < EepromWords)
                r.read_data[31:16] = station_mac[16*word_addr +: 16];
            end
            OfsIcr: begin
              r.read_data = nic_regs.icr;
              nic_regs.icr = '0;
            end
            OfsIms:  r.read_data = nic_regs.ims;
            OfsRctl: r.read_data = nic_regs.rctl;
            OfsTctl: r.read_data = nic_regs.tctl;
            OfsRdbal: r.read_data = nic_regs.rdbal;
            OfsRdbah: r.read_data = nic_regs.rdbah;
            OfsRdlen: r.read_data = nic_regs.rdlen;
            OfsRdh:   r.read_data = {16'h0, nic_regs.rdh};
            OfsRdt:   r.read_data = {16'h0, nic_regs.rdt};
            OfsTdbal: r.read_data = nic_regs.tdbal;
            OfsTdbah: r.read_data = nic_regs.tdbah;
            OfsTdlen: r.read_data = nic_regs.tdlen;
            OfsTdh:   r.read_data = {16'h0, nic_regs.tdh};
            OfsTdt:   r.read_data = {16'h0, nic_regs.tdt};
            OfsRal0:  r.read_data = station_mac[31:0];
            OfsRah0:  r.read_data = {16'h0, station_mac[47:32]} | AddrValid;
            default:  r.read_data = '0;
          endcase
        end else begin
          case (b.reg_offset)
            OfsCtrl: begin
              if (b.write_data[CtrlRstBit]) nic_regs = '0;
              else nic_regs.ctrl = b.write_data;
            end
            OfsRctl:  nic_regs.rctl = b.write_data;
            OfsTctl:  nic_regs.tctl = b.write_data;
            OfsIms:   nic_regs.ims = nic_regs.ims | b.write_data;
            OfsImc:   nic_regs.ims = nic_regs.ims & ~b.write_data;
            OfsIcr:   nic_regs.icr = nic_regs.icr & ~b.write_data;
            OfsEerd:  nic_regs.eerd = b.write_data;
            OfsRdbal: nic_regs.rdbal = b.write_data & BaseMask;
            OfsRdbah: nic_regs.rdbah = b.write_data;
            OfsRdlen: nic_regs.rdlen = b.write_data & LenMask;
            OfsRdh:   nic_regs.rdh = b.write_data[15:0];
            OfsRdt:   nic_regs.rdt = b.write_data[15:0];
            OfsTdbal: nic_regs.tdbal = b.write_data & BaseMask;
            OfsTdbah: nic_regs.tdbah = b.write_data;
            OfsTdlen: nic_regs.tdlen = b.write_data & LenMask;
            OfsTdh:   nic_regs.tdh = b.write_data[15:0];
            OfsTdt:   nic_regs.tdt = b.write_data[15:0];
            default: ;
          endcase
        end
      end
      OP_RAISE: nic_regs.icr = nic_regs.icr | b.write_data;
      default: ;
    endcase
    tx_n = nic_regs.tdlen[31:4];
    rx_n = nic_regs.rdlen[31:4];
    r.tx_ring_entries = tx_n;
    r.rx_ring_entries = rx_n;
    r.tx_ready = nic_regs.tctl[RingEnBit] && tx_n != '0 &&
                 (nic_regs.tdbal != '0 || nic_regs.tdbah != '0) && bus_master_on;
    r.rx_ready = nic_regs.rctl[RingEnBit] && rx_n != '0 &&
                 (nic_regs.rdbal != '0 || nic_regs.rdbah != '0) && bus_master_on;
    r.irq_pending = |(nic_regs.icr & nic_regs.ims);
    r.station_ok = station_mac != '0 && station_mac != '1 && !station_mac[0];
    return r;
  endfunction

  function automatic req_t make_beat(logic [OpW-1:0] op, logic [OfsW-1:0] ofs,
                                     logic [SizeW-1:0] size, logic [DataW-1:0] data);
    req_t b;
    b.opcode = op;
    b.reg_offset = ofs;
    b.access_size = size;
    b.write_data = data;
    return b;
  endfunction

  function automatic req_t rand_beat();
    req_t b;
    int   pick;
    pick = $urandom_range(0, 99);
    b.opcode = ($urandom_range(0, 1) != 0) ? OP_READ : OP_WRITE;
    b.access_size = LegalSize;
    b.write_data = $urandom;
    b.reg_offset = known_ofs[$urandom_range(0, 20)];
    if (pick >= 70 && pick < 78) begin
      b.reg_offset = {15'($urandom), 2'b00};
    end else if (pick >= 78 && pick < 88) begin
      b.opcode = OP_RAISE;
      b.reg_offset = 17'($urandom);
      b.access_size = 4'($urandom_range(0, 8));
      if ($urandom_range(0, 1) != 0) b.write_data = 32'd1 << $urandom_range(0, 31);
    end else if (pick >= 88 && pick < 96) begin
      b.reg_offset = 17'($urandom);
      b.access_size = 4'($urandom_range(0, 8));
      if (b.access_size == LegalSize && b.reg_offset[1:0] == 2'b00)
        b.reg_offset[$urandom_range(0, 1)] = 1'b1;
    end else if (pick >= 96) begin
      b.opcode = OpUnused;
      b.reg_offset = 17'($urandom);
      b.access_size = 4'($urandom_range(0, 8));
    end
    if (b.opcode == OP_WRITE) begin
      case (b.reg_offset)
        OfsCtrl: if ($urandom_range(0, 15) != 0) b.write_data[CtrlRstBit] = 1'b0;
        OfsRctl, OfsTctl: if ($urandom_range(0, 3) != 0) b.write_data[RingEnBit] = 1'b1;
        OfsEerd: if ($urandom_range(0, 3) != 0) b.write_data[23:8] = 16'($urandom_range(0, 3));
        OfsRdlen, OfsTdlen: if ($urandom_range(0, 1) != 0)
          b.write_data = 32'($urandom_range(0, 15)) << 7;
        OfsRdbal, OfsRdbah, OfsTdbal, OfsTdbah: if ($urandom_range(0, 5) == 0)
          b.write_data = '0;
        OfsIms, OfsImc, OfsIcr: if ($urandom_range(0, 1) != 0)
          b.write_data = 32'd1 << $urandom_range(0, 31);
        default: ;
      endcase
    end
    return b;
  endfunction

  task automatic queue_beat(req_t b);
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [MacW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == CFG_MAC_ADDRESS) station_mac = data;
    else bus_master_on = data[0];
  endtask

  task automatic close_cfg();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  task automatic wait_drained();
    while (results_seen != beats_queued) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %0s expected %h got %h", results_seen, name, want, got);
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_rsp_q.push_back(predict_beat(beat_now));
        beats_sent++;
        if (beat_now.opcode == OP_READ) n_reads++;
        else if (beat_now.opcode == OP_WRITE) n_writes++;
        else if (beat_now.opcode == OP_RAISE) n_raises++;
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        gap_left = send_burst ? 0 : $urandom_range(0, 7);
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          beat_now = pending_beats.pop_front();
          req_if.valid       <= 1'b1;
          req_if.opcode      <= beat_now.opcode;
          req_if.reg_offset  <= beat_now.reg_offset;
          req_if.access_size <= beat_now.access_size;
          req_if.write_data  <= beat_now.write_data;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t got, want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got.read_data       = rsp_if.read_data;
        got.access_error    = rsp_if.access_error;
        got.irq_pending     = rsp_if.irq_pending;
        got.tx_ready        = rsp_if.tx_ready;
        got.rx_ready        = rsp_if.rx_ready;
        got.tx_ring_entries = rsp_if.tx_ring_entries;
        got.rx_ring_entries = rsp_if.rx_ring_entries;
        got.station_ok      = rsp_if.station_ok;
        if (expected_rsp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result beat with nothing outstanding");
        end else begin
          want = expected_rsp_q.pop_front();
          if (want.access_error) n_flagged++;
          check_field("read_data", got.read_data, want.read_data);
          check_field("access_error", 32'(got.access_error), 32'(want.access_error));
          check_field("irq_pending", 32'(got.irq_pending), 32'(want.irq_pending));
          check_field("tx_ready", 32'(got.tx_ready), 32'(want.tx_ready));
          check_field("rx_ready", 32'(got.rx_ready), 32'(want.rx_ready));
          check_field("tx_ring_entries", 32'(got.tx_ring_entries), 32'(want.tx_ring_entries));
          check_field("rx_ring_entries", 32'(got.rx_ring_entries), 32'(want.rx_ring_entries));
          check_field("station_ok", 32'(got.station_ok), 32'(want.station_ok));
        end
        results_seen++;
        if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
        stall_left = take_burst ? 0 : $urandom_range(0, 7);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      rsp_if.ready <= (stall_left == 0);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("gigabit_nic_register_block verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [MacW-1:0] mac_pick;
    req_if.valid       = 1'b0;
    req_if.opcode      = '0;
    req_if.reg_offset  = '0;
    req_if.access_size = '0;
    req_if.write_data  = '0;
    rsp_if.ready       = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_MAC_ADDRESS;
    cfg_data_i         = '0;
    nic_regs           = '0;
    station_mac        = '0;
    bus_master_on      = 1'b1;
    idle_cycles        = 0;
    send_burst         = 1'b0;
    take_burst         = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_cfg(CFG_MAC_ADDRESS, 48'h6655_4433_2200);
    write_cfg(CFG_BUS_MASTER, 48'd1);
    close_cfg();

    // directed: fixed registers, interrupt regs, eeprom words, rings, bad beats
    queue_beat(make_beat(OP_READ, OfsStatus, LegalSize, '0));
    queue_beat(make_beat(OP_READ, OfsEecd, LegalSize, '0));
    queue_beat(make_beat(OP_WRITE, OfsCtrl, LegalSize, 32'hFBFF_FFFF));
    queue_beat(make_beat(OP_READ, OfsCtrl, LegalSize, '0));
    queue_beat(make_beat(OP_WRITE, OfsIms, LegalSize, 32'hFFFF_FFFF));
    queue_beat(make_beat(OP_WRITE, OfsImc, LegalSize, 32'hFFFF_0000));
    queue_beat(make_beat(OP_READ, OfsImc, LegalSize, '0));
    queue_beat(make_beat(OP_RAISE, 17'h1FFFF, 4'hF, 32'h8001_8001));
    queue_beat(make_beat(OP_WRITE, OfsIcr, LegalSize, 32'h0000_0001));
    queue_beat(make_beat(OP_READ, OfsIcr, LegalSize, '0));
    queue_beat(make_beat(OP_READ, OfsIcr, LegalSize, '0));
    queue_beat(make_beat(OP_WRITE, OfsEerd, LegalSize, 32'h0000_0211));
    queue_beat(make_beat(OP_READ, OfsEerd, LegalSize, '0));
    queue_beat(make_beat(OP_WRITE, OfsEerd, LegalSize, 32'hFFFF_FFFF));
    queue_beat(make_beat(OP_READ, OfsEerd, LegalSize, '0));
    queue_beat(make_beat(OP_WRITE, OfsRdbal, LegalSize, 32'hFFFF_FFFF));
    queue_beat(make_beat(OP_WRITE, OfsRdlen, LegalSize, 32'hFFFF_FFFF));
    queue_beat(make_beat(OP_WRITE, OfsRctl, LegalSize, 32'h0000_0002));
    queue_beat(make_beat(OP_WRITE, OfsRdh, LegalSize, 32'hFFFF_FFFF));
    queue_beat(make_beat(OP_READ, OfsRdh, LegalSize, '0));
    queue_beat(make_beat(OP_WRITE, OfsTdbah, LegalSize, 32'h0000_0001));
    queue_beat(make_beat(OP_WRITE, OfsTdlen, LegalSize, 32'h0000_00FF));
    queue_beat(make_beat(OP_WRITE, OfsTctl, LegalSize, 32'h0000_0002));
    queue_beat(make_beat(OP_READ, OfsRal0, LegalSize, '0));
    queue_beat(make_beat(OP_READ, OfsRah0, LegalSize, '0));
    queue_beat(make_beat(OP_WRITE, OfsCtrl, LegalSize, 32'h0400_0000));
    queue_beat(make_beat(OP_READ, OfsStatus, 4'd0, '0));
    queue_beat(make_beat(OP_WRITE, OfsRctl, 4'd8, 32'hFFFF_FFFF));
    queue_beat(make_beat(OP_WRITE, 17'h00102, LegalSize, 32'hFFFF_FFFF));
    queue_beat(make_beat(OpUnused, OfsIcr, LegalSize, 32'hFFFF_FFFF));
    queue_beat(make_beat(OP_WRITE, 17'h1FFFC, LegalSize, 32'hFFFF_FFFF));
    queue_beat(make_beat(OP_READ, 17'h1FFFC, LegalSize, '0));
    wait_drained();

    for (int p = 0; p < Phases; p++) begin
      case (p)
        0: mac_pick = '0;
        1: mac_pick = '1;
        2: mac_pick = {16'($urandom), 32'($urandom)} & ~48'd1;
        3: mac_pick = {16'($urandom), 32'($urandom)} | 48'd1;
        default: mac_pick = 48'hFFFF_FFFF_FFFE;
      endcase
      write_cfg(CFG_MAC_ADDRESS, mac_pick);
      write_cfg(CFG_BUS_MASTER, (p == 1) ? 48'd0 : (p == 3) ? 48'($urandom_range(0, 1)) : 48'd1);
      close_cfg();
      for (int i = 0; i < PhaseBeats; i++) queue_beat(rand_beat());
      wait_drained();
    end

    $display("sent %0d beats: %0d reads, %0d writes, %0d raises, %0d flagged as bad access",
             beats_sent, n_reads, n_writes, n_raises, n_flagged);
    $display("%0d station address / bus master settings, %0d mismatches",
             n_settings, mismatches);
    if (mismatches == 0 && expected_rsp_q.size() == 0 && results_seen == beats_queued) begin
      $display("gigabit_nic_register_block verification clean");
    end else begin
      $display("gigabit_nic_register_block verification failed");
    end
    $finish;
  end

endmodule

@@ gigabit_nic_register_block.f @@
rtl/gnic_pkg.sv
rtl/gnic_if.sv
rtl/gnic_regs.sv
rtl/gnic_rsp_fifo.sv
rtl/gigabit_nic_register_block.sv
tb/sv/tb.sv
